>>> src/rfd_pkg.sv
// shared types and constants for the rpc frame deframer
package rfd_pkg;

    // deframer phase
    typedef enum logic [1:0] {
        PH_HUNT1   = 2'd0,
        PH_HUNT2   = 2'd1,
        PH_HEADER  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // input beat kind (s_axis_tuser)
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // result kind (m_axis_tuser)
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ABORT   = 2'd2
    } kind_t;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_SOF_FIRST  = 2'd0;
    localparam logic [1:0] REG_SOF_SECOND = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    localparam int HDR_STORE_DEPTH = 5;
    localparam logic [2:0] HDR_LAST_IDX = 3'd5;
    localparam int OUT_DATA_W = 56;
    localparam int TIMEOUT_W = 16;

endpackage

>>> src/rpc_frame_deframer.sv
// rpc frame deframer: start-of-frame hunt, header collection, payload streaming
//
// usage
//   s_axis carries one beat per received byte or time tick: tuser = 0 for a
//   byte in tdata, tuser = 1 for a tick. the block hunts for the two
//   configured start bytes, collects six header bytes (frame type, service,
//   command, request id, length low, length high) and emits one header beat
//   on m_axis, then one beat per payload byte. tlast marks the final beat of a
//   frame (or the header beat when the length is zero) and every abort beat.
//   with a non-zero timeout, that many ticks without a byte inside a frame
//   produce an abort beat (tuser = 2) and the hunt restarts.
//   apb registers: 0x0 first start byte, 0x4 second start byte, 0x8 timeout.
// pipeline and throughput
//   one beat per cycle while the m_axis receiver is ready; an accepted beat
//   is held in the input register and its result, if any, is loaded into the
//   result register when the input register advances; it drives m_axis_tvalid.
// reset and stall
//   reset zeroes the config, valid and state registers (deframer hunting).
//   when the m_axis receiver stalls, the result register holds and the input
//   register holds one more beat; s_axis_tready drops only when both are full.
module rpc_frame_deframer
    import rfd_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // rx_byte
    input  logic [0:0]            s_axis_tuser,   // operation
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // msg_type[7:0], service[15:8], command[23:16], req_tag[31:24],
    // body_len[47:32], payload_byte[55:48]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // kind
    output logic                  m_axis_tlast,   // last
    // apb configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > TIMEOUT_W) ? TICK_COUNT_WIDTH : TIMEOUT_W;

    // configuration registers
    logic [7:0]           sof_first_reg;
    logic [7:0]           sof_second_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // input register
    logic       in_valid_reg;
    op_t        in_op_reg;
    logic [7:0] in_byte_reg;

    // deframer state
    phase_t                      phase_reg, phase_next;
    logic [2:0]                  hdr_idx_reg, hdr_idx_next;
    logic [7:0]                  hdr_store_reg [HDR_STORE_DEPTH];
    logic [15:0]                 remain_reg, remain_next;
    logic [TICK_COUNT_WIDTH-1:0] idle_reg, idle_next;

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    kind_t                 out_kind_reg;
    logic                  out_last_reg;

    // combinational result
    logic                  res_valid;
    logic [OUT_DATA_W-1:0] res_data;
    kind_t                 res_kind;
    logic                  res_last;

    logic                  advance;
    logic                  cfg_wr;
    logic [TICK_COUNT_WIDTH-1:0] idle_inc;
    logic                  tick_live;
    logic                  timed_out;
    logic [15:0]           hdr_len;
    logic [15:0]           remain_dec;

    // handshake: the input register moves on when the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SOF_FIRST:  prdata = {24'd0, sof_first_reg};
            REG_SOF_SECOND: prdata = {24'd0, sof_second_reg};
            REG_TIMEOUT:    prdata = {16'd0, timeout_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_first_reg  <= 8'd0;
            sof_second_reg <= 8'd0;
            timeout_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SOF_FIRST:  sof_first_reg  <= pwdata[7:0];
                REG_SOF_SECOND: sof_second_reg <= pwdata[7:0];
                REG_TIMEOUT:    timeout_reg    <= pwdata[TIMEOUT_W-1:0];
                default:        ;
            endcase
        end
    end

    // shared terms
    assign idle_inc   = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;
    assign tick_live  = (phase_reg != PH_HUNT1) && (timeout_reg != '0);
    // saturated counter compared against the timeout at a common width
    assign timed_out  = (CMP_W'(idle_inc) >= CMP_W'(timeout_reg));
    assign hdr_len    = {in_byte_reg, hdr_store_reg[4]};
    assign remain_dec = (remain_reg != 16'd0) ? remain_reg - 16'd1 : remain_reg;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        remain_next  = remain_reg;
        idle_next    = idle_reg;
        if (in_op_reg == OP_TICK)
        begin
            if (tick_live)
            begin
                if (timed_out)
                begin
                    // byte timeout: drop the frame and hunt again
                    phase_next   = PH_HUNT1;
                    hdr_idx_next = 3'd0;
                    remain_next  = 16'd0;
                    idle_next    = '0;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
        end
        else
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (in_byte_reg == sof_first_reg)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    // a mismatching byte is not retried as a first start byte
                    if (in_byte_reg == sof_second_reg)
                    begin
                        phase_next   = PH_HEADER;
                        hdr_idx_next = 3'd0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_HEADER:
                begin
                    if (hdr_idx_reg != HDR_LAST_IDX)
                    begin
                        hdr_idx_next = hdr_idx_reg + 3'd1;
                    end
                    else
                    begin
                        hdr_idx_next = 3'd0;
                        if (hdr_len == 16'd0)
                        begin
                            phase_next = PH_HUNT1;
                        end
                        else
                        begin
                            phase_next  = PH_PAYLOAD;
                            remain_next = hdr_len;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 16'd0)
                        phase_next = PH_HUNT1;
                end
                default: ;
            endcase
        end
    end

    // result of the current beat
    always_comb
    begin
        res_valid = 1'b0;
        res_data  = '0;
        res_kind  = KIND_HEADER;
        res_last  = 1'b0;
        if (in_op_reg == OP_TICK)
        begin
            if (tick_live && timed_out)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_ABORT;
                res_last  = 1'b1;
            end
        end
        else if (phase_reg == PH_HEADER && hdr_idx_reg == HDR_LAST_IDX)
        begin
            res_valid = 1'b1;
            res_kind  = KIND_HEADER;
            res_data  = {8'd0, hdr_len, hdr_store_reg[3], hdr_store_reg[2],
                         hdr_store_reg[1], hdr_store_reg[0]};
            res_last  = (hdr_len == 16'd0);
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            res_valid = 1'b1;
            res_kind  = KIND_PAYLOAD;
            res_data  = {in_byte_reg, 48'd0};
            res_last  = (remain_dec == 16'd0);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= op_t'(s_axis_tuser[0]);
            in_byte_reg <= s_axis_tdata;
        end
    end

    // deframer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            hdr_idx_reg <= 3'd0;
            remain_reg  <= 16'd0;
            idle_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            remain_reg  <= remain_next;
            idle_reg    <= idle_next;
        end
    end

    // header bytes, written before they are read
    always_ff @(posedge clk)
    begin
        if (advance && in_op_reg == OP_BYTE && phase_reg == PH_HEADER
            && hdr_idx_reg != HDR_LAST_IDX)
            hdr_store_reg[hdr_idx_reg] <= in_byte_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

endmodule

>>> sim/rpc_frame_deframer_test.sv
// self-checking stream testbench for the rpc frame deframer
module rpc_frame_deframer_test
    import rfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // idle counter width of the instance below
    localparam int TICK_W = 16;

    // one result beat, split into its fields
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_type;
        logic [7:0]  service;
        logic [7:0]  command;
        logic [7:0]  req_tag;
        logic [15:0] body_len;
        logic [7:0]  payload_byte;
        logic        last;
    } deframe_result_t;

    // shadow of the deframer: follows every accepted input beat and keeps
    // the result beats that the block still owes
    class deframer_shadow;
        logic [7:0]        sof_first;
        logic [7:0]        sof_second;
        logic [15:0]       timeout_ticks;
        phase_t            phase;
        logic [2:0]        hdr_count;
        logic [7:0]        hdr_bytes [HDR_STORE_DEPTH];
        logic [15:0]       remaining;
        logic [TICK_W-1:0] idle_ticks;
        deframe_result_t   due_results [$];
        int                mismatches;

        function new();
            sof_first     = '0;
            sof_second    = '0;
            timeout_ticks = '0;
            phase         = PH_HUNT1;
            hdr_count     = '0;
            remaining     = '0;
            idle_ticks    = '0;
            mismatches    = 0;
            foreach (hdr_bytes[i])
                hdr_bytes[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SOF_FIRST:  sof_first = value[7:0];
                REG_SOF_SECOND: sof_second = value[7:0];
                REG_TIMEOUT:    timeout_ticks = value[15:0];
                default: ;
            endcase
        endfunction

        // returns 1 when the beat did something, 0 for a tick that is ignored
        function bit take_beat(op_t op, logic [7:0] data);
            deframe_result_t res;
            logic [15:0]     len;
            res = '0;
            if (op == OP_TICK)
            begin
                // ticks only count inside a frame and with a timeout set
                if (phase == PH_HUNT1 || timeout_ticks == 0)
                    return 1'b0;
                if (idle_ticks != {TICK_W{1'b1}})
                    idle_ticks++;
                if (32'(idle_ticks) >= 32'(timeout_ticks))
                begin
                    phase      = PH_HUNT1;
                    hdr_count  = '0;
                    remaining  = '0;
                    idle_ticks = '0;
                    res.kind   = KIND_ABORT;
                    res.last   = 1'b1;
                    due_results.push_back(res);
                end
                return 1'b1;
            end
            idle_ticks = '0;
            case (phase)
                PH_HUNT1:
                begin
                    if (data == sof_first)
                        phase = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    // a wrong second byte is dropped, not retried as a first byte
                    if (data == sof_second)
                    begin
                        phase     = PH_HEADER;
                        hdr_count = '0;
                    end
                    else
                        phase = PH_HUNT1;
                end
                PH_HEADER:
                begin
                    if (hdr_count < HDR_LAST_IDX)
                    begin
                        hdr_bytes[hdr_count] = data;
                        hdr_count++;
                    end
                    else
                    begin
                        len       = {data, hdr_bytes[4]};
                        hdr_count = '0;
                        if (len == 0)
                            phase = PH_HUNT1;
                        else
                        begin
                            phase     = PH_PAYLOAD;
                            remaining = len;
                        end
                        res.kind     = KIND_HEADER;
                        res.msg_type = hdr_bytes[0];
                        res.service  = hdr_bytes[1];
                        res.command  = hdr_bytes[2];
                        res.req_tag  = hdr_bytes[3];
                        res.body_len = len;
                        res.last     = (len == 0);
                        due_results.push_back(res);
                    end
                end
                default:
                begin
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                        phase = PH_HUNT1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = data;
                    res.last         = (remaining == 0);
                    due_results.push_back(res);
                end
            endcase
            return 1'b1;
        endfunction

        function void show_beat(string tag, deframe_result_t r);
            $display("%s kind=%0d mt=%h sv=%h cmd=%h tag=%h len=%h pb=%h last=%b",
                     tag, r.kind, r.msg_type, r.service, r.command,
                     r.req_tag, r.body_len, r.payload_byte, r.last);
        endfunction

        function void match_result(deframe_result_t got);
            deframe_result_t exp;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    show_beat("unexpected result beat:", got);
                return;
            end
            exp = due_results.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    show_beat("result mismatch, expected:", exp);
                    show_beat("                 actual:  ", got);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // anything still owed at the end is a miss
        function void close_out();
            if (due_results.size() != 0)
            begin
                if (mismatches < 10)
                    $display("%0d result beats never arrived", due_results.size());
                mismatches += due_results.size();
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // rx_byte
    logic [0:0]  s_axis_tuser = '0;    // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // msg_type, service, command, req_tag, body_len, payload_byte
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;         // kind
    logic        m_axis_tlast;         // last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    deframer_shadow sb = new();

    // sender burst bookkeeping and count of beats that did something
    int burst_left = 0;
    int beats_used = 0;

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    int stall_cycle = 0;

    rpc_frame_deframer #(
        .TICK_COUNT_WIDTH(TICK_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver: a few stall modes, each held for a random stretch
    always @(posedge clk)
    begin
        stall_cycle++;
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        else
            stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_cycle % 5 != 0);
        endcase
    end

    // result monitor: every accepted result beat is checked against the shadow
    always @(posedge clk)
    begin
        deframe_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind         = kind_t'(m_axis_tuser);
            got.msg_type     = m_axis_tdata[7:0];
            got.service      = m_axis_tdata[15:8];
            got.command      = m_axis_tdata[23:16];
            got.req_tag      = m_axis_tdata[31:24];
            got.body_len     = m_axis_tdata[47:32];
            got.payload_byte = m_axis_tdata[55:48];
            got.last         = m_axis_tlast;
            sb.match_result(got);
        end
    end

    // send one input beat; the sender works in bursts with random gaps between
    task automatic send_beat(op_t op, logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (sb.take_beat(op, data))
            beats_used++;
        burst_left--;
    endtask

    // a short run of ticks inside a frame, kept below the timeout
    task automatic stray_ticks();
        int top;
        if ($urandom_range(0, 5) != 0)
            return;
        if (sb.timeout_ticks == 0)
            top = 3;
        else
            top = (sb.timeout_ticks - 1 > 3) ? 3 : sb.timeout_ticks - 1;
        if (top > 0)
            repeat ($urandom_range(1, top)) send_beat(OP_TICK, 8'($urandom));
    endtask

    // stop sending and wait for every owed result, then for the pipeline to empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(logic [7:0] first, logic [7:0] second, logic [15:0] ticks);
        drain();
        reg_write(REG_SOF_FIRST, {24'd0, first});
        reg_write(REG_SOF_SECOND, {24'd0, second});
        reg_write(REG_TIMEOUT, {16'd0, ticks});
    endtask

    // one random scenario: mostly whole frames, plus broken starts,
    // frames cut off by the timeout and plain line noise
    task automatic send_scenario();
        int          pick;
        int          len;
        int          cut;
        logic [7:0]  wrong;
        logic [15:0] long_len;
        pick = $urandom_range(0, 99);
        // some junk ahead of the frame
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_beat(OP_BYTE, 8'($urandom));
        if (pick < 65)
        begin
            // well-formed frame, mostly short payloads
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(0, 6);
            else if ($urandom_range(0, 5) != 0)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(41, 200);
            send_beat(OP_BYTE, sb.sof_first);
            stray_ticks();
            send_beat(OP_BYTE, sb.sof_second);
            repeat (4)
            begin
                stray_ticks();
                send_beat(OP_BYTE, 8'($urandom));
            end
            send_beat(OP_BYTE, 8'(len));
            stray_ticks();
            send_beat(OP_BYTE, 8'(len >> 8));
            repeat (len)
            begin
                stray_ticks();
                send_beat(OP_BYTE, 8'($urandom));
            end
        end
        else if (pick < 75)
        begin
            // broken start: the second byte is wrong; often it is the first
            // start byte again, which must not restart the hunt
            if (sb.sof_first != sb.sof_second && $urandom_range(0, 1) == 0)
                wrong = sb.sof_first;
            else
                wrong = sb.sof_second ^ 8'($urandom_range(1, 255));
            send_beat(OP_BYTE, sb.sof_first);
            send_beat(OP_BYTE, wrong);
            if ($urandom_range(0, 1) == 0)
                send_beat(OP_BYTE, sb.sof_second);
        end
        else if (pick < 90 && sb.timeout_ticks != 0 && sb.timeout_ticks <= 64)
        begin
            // frame cut off by ticks: in the start, the header or the payload
            send_beat(OP_BYTE, sb.sof_first);
            if ($urandom_range(0, 3) != 0)
            begin
                send_beat(OP_BYTE, sb.sof_second);
                cut = $urandom_range(0, 6);
                if (cut < 6)
                    repeat (cut) send_beat(OP_BYTE, 8'($urandom));
                else
                begin
                    long_len = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(1, 65535));
                    repeat (4) send_beat(OP_BYTE, 8'($urandom));
                    send_beat(OP_BYTE, long_len[7:0]);
                    send_beat(OP_BYTE, long_len[15:8]);
                    cut = $urandom_range(0, 5);
                    if (cut >= long_len)
                        cut = long_len - 1;
                    repeat (cut) send_beat(OP_BYTE, 8'($urandom));
                end
            end
            repeat (sb.timeout_ticks) send_beat(OP_TICK, 8'($urandom));
        end
        else
        begin
            // noise: bytes and ticks in any mix
            repeat ($urandom_range(1, 8))
                send_beat(op_t'($urandom_range(0, 1)), 8'($urandom));
        end
    endtask

    task automatic random_phase(int target);
        int start;
        start = beats_used;
        while (beats_used - start < target)
            send_scenario();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: start bytes a5 5a, timeout of three ticks
        apply_setting(8'hA5, 8'h5A, 16'd3);
        send_beat(OP_TICK, 8'h00);      // tick while hunting is ignored
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_BYTE, 8'hA5);      // wrong second byte, not a new first byte
        send_beat(OP_BYTE, 8'h5A);      // still hunting, so no header follows
        // all-ones header fields with zero length: header beat carries last
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_BYTE, 8'h5A);
        repeat (4) send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'h00);
        // all-zero header fields, maximum length, then aborted by the timeout
        send_beat(OP_BYTE, 8'hA5);
        send_beat(OP_BYTE, 8'h5A);
        repeat (4) send_beat(OP_BYTE, 8'h00);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'hFF);
        send_beat(OP_BYTE, 8'h00);
        repeat (3) send_beat(OP_TICK, 8'hFF);

        // random phases over a spread of settings, extremes included
        apply_setting(8'h00, 8'h00, 16'd0);
        random_phase(260);
        apply_setting(8'hFF, 8'hFF, 16'd1);
        random_phase(260);
        apply_setting(8'($urandom), 8'($urandom), 16'($urandom_range(2, 12)));
        random_phase(260);
        begin
            logic [7:0] same;
            same = 8'($urandom);
            apply_setting(same, same, 16'd0);
        end
        random_phase(260);

        // largest timeout: a stretch of ticks inside a frame does not abort it
        begin
            logic [7:0] first_sof;
            logic [7:0] second_sof;
            first_sof  = 8'($urandom);
            second_sof = 8'($urandom);
            // a one-tick timeout closes any frame left open
            apply_setting(first_sof, second_sof, 16'd1);
            send_beat(OP_TICK, 8'h00);
            apply_setting(first_sof, second_sof, 16'hFFFF);
            send_beat(OP_BYTE, first_sof);
            repeat (60) send_beat(OP_TICK, 8'($urandom));
        end
        random_phase(260);

        apply_setting(8'($urandom), 8'($urandom), 16'($urandom_range(1, 6)));
        random_phase(260);

        drain();
        repeat (10) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit, well above the slowest legal run
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
src/rfd_pkg.sv
src/rpc_frame_deframer.sv
sim/rpc_frame_deframer_test.sv
